FILE: sv/swm_pkg.sv
// shared types and constants for the sliding window maximum block
package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int WIN_W          = 7;
  localparam int POS_W          = 8;
  localparam int FILL_W         = 7;
  localparam int WINDOW_MAX_DEF = 64;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
    logic [WIN_W-1:0]           win;
  } swm_item_t;

endpackage

FILE: sv/swm_if.sv
// channel interfaces for samples, maxima and configuration writes
interface swm_in_if import swm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink (input valid, input window_size, output ready);
endinterface

FILE: sv/sliding_window_maximum_top.sv
// top level of the sliding window maximum block
// Streams signed 32-bit samples on the samples channel (sample, restart) and
// returns the largest of the last window_size samples on the maxima channel.
// No result is given until window_size samples have arrived since reset or
// the last restart; restart clears the candidate list before its sample.
// window_size is written on the cfg channel, which is always ready; 0 acts as
// 1 and values above WINDOW_MAX act as WINDOW_MAX. Write it only when idle.
// A two-entry queue takes samples while the deque sequencer works.
// Each sample steps through the sequencer states idle, age, pop, push and
// output (output only when a result is due), staying in pop while candidates
// are popped from the back, with one read of the candidate memory per cycle;
// each sample is popped at most once. When the receiver stalls, the result
// register holds and the sequencer waits at its output step; the queue keeps
// taking samples until full.
// Reset clears counts, deque pointers and window_size to 1; the candidate
// memory needs no clearing.
module sliding_window_maximum_top import swm_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  swm_cfg_if.sink   cfg,
  swm_in_if.sink    samples,
  swm_out_if.source maxima
);

  logic [WIN_W-1:0] window_size;
  logic             item_valid;
  logic             item_ready;
  swm_item_t        item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      window_size <= cfg.window_size;
    end
  end

  swm_front #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .window_size(window_size),
    .samples    (samples),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  swm_back #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .maxima    (maxima)
  );

endmodule

FILE: sv/swm_front.sv
// front end: accepts samples, resolves the effective window and queues them
module swm_front import swm_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [WIN_W-1:0] window_size,
  swm_in_if.sink           samples,
  output logic             item_valid,
  input  logic             item_ready,
  output swm_item_t        item
);

  swm_item_t        entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [WIN_W-1:0] win_eff;
  logic             push;
  logic             pop;

  always_comb begin
    win_eff = window_size;
    if (window_size == '0) begin
      win_eff = WIN_W'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      win_eff = WIN_W'(WINDOW_MAX);
    end
  end

  assign samples.ready = (count != 2'd2);
  assign push          = samples.valid && samples.ready;
  assign item_valid    = (count != 2'd0);
  assign pop           = item_valid && item_ready;
  assign item          = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{sample: samples.sample, restart: samples.restart, win: win_eff};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: sv/swm_back.sv
// back end: monotonic deque sequencer over the candidate memory
module swm_back import swm_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  swm_item_t item,
  swm_out_if.source maxima
);

  localparam int AW      = $clog2(WINDOW_MAX);
  localparam int OW      = $clog2(WINDOW_MAX + 1);
  localparam int SW      = OW + 1;
  localparam int ENTRY_W = SAMPLE_W + POS_W;

  typedef enum logic [2:0] {S_IDLE, S_AGE, S_POP, S_PUSH, S_OUT} state_t;

  state_t                     state, state_next;
  logic [AW-1:0]              head, head_next, head_p;
  logic [OW-1:0]              occ, occ_next, occ_p;
  logic [POS_W-1:0]           pos, pos_next;
  logic [FILL_W-1:0]          filled, filled_next, filled_inc;
  logic signed [SAMPLE_W-1:0] smp, smp_next;
  logic [WIN_W-1:0]           win, win_next;
  logic                       front_new, front_new_next;
  logic                       out_valid, out_valid_next;
  logic signed [SAMPLE_W-1:0] out_max, out_max_next;

  logic [ENTRY_W-1:0]         mem [WINDOW_MAX];
  logic [ENTRY_W-1:0]         rd_data;
  logic [ENTRY_W-1:0]         wr_data;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en;
  logic                       wr_en;
  logic signed [SAMPLE_W-1:0] rd_val;
  logic [POS_W-1:0]           rd_pos;
  logic [POS_W-1:0]           age;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [OW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= SW'(WINDOW_MAX)) begin
      sum = sum - SW'(WINDOW_MAX);
    end
    return AW'(sum);
  endfunction

  function automatic logic [OW-1:0] back_ofs(input logic [OW-1:0] n);
    return (n == '0) ? '0 : n - OW'(1);
  endfunction

  assign rd_val = rd_data[ENTRY_W-1 -: SAMPLE_W];
  assign rd_pos = rd_data[POS_W-1:0];
  assign age    = pos - rd_pos;

  assign item_ready        = (state == S_IDLE);
  assign maxima.valid      = out_valid;
  assign maxima.window_max = out_max;

  always_comb begin
    state_next     = state;
    head_next      = head;
    occ_next       = occ;
    pos_next       = pos;
    filled_next    = filled;
    smp_next       = smp;
    win_next       = win;
    front_new_next = front_new;
    out_valid_next = out_valid;
    out_max_next   = out_max;
    head_p         = head;
    occ_p          = occ;
    filled_inc     = (filled == '1) ? filled : filled + FILL_W'(1);
    rd_en          = 1'b0;
    rd_addr        = head;
    wr_en          = 1'b0;
    wr_addr        = head;
    wr_data        = {smp, pos};

    if (out_valid && maxima.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          smp_next = item.sample;
          win_next = item.win;
          rd_en    = 1'b1;
          if (item.restart) begin
            head_next   = '0;
            occ_next    = '0;
            pos_next    = '0;
            filled_next = '0;
            rd_addr     = '0;
          end
          state_next = S_AGE;
        end
      end
      S_AGE: begin
        if (filled >= FILL_W'(win) && occ != '0 && age >= {1'b0, win}) begin
          head_next = slot(head, OW'(1));
          occ_next  = occ - OW'(1);
        end
        rd_en      = 1'b1;
        rd_addr    = slot(head_next, back_ofs(occ_next));
        state_next = S_POP;
      end
      S_POP: begin
        if (occ != '0 && rd_val <= smp) begin
          occ_next = occ - OW'(1);
          rd_en    = 1'b1;
          rd_addr  = slot(head, back_ofs(occ_next));
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (occ == OW'(WINDOW_MAX)) begin
          head_p = slot(head, OW'(1));
          occ_p  = occ - OW'(1);
        end
        wr_en          = 1'b1;
        wr_addr        = slot(head_p, occ_p);
        head_next      = head_p;
        occ_next       = occ_p + OW'(1);
        pos_next       = pos + POS_W'(1);
        filled_next    = filled_inc;
        front_new_next = (occ_p == '0);
        rd_en          = (occ_p != '0);
        rd_addr        = head_p;
        state_next     = (filled_inc >= FILL_W'(win)) ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (!out_valid || maxima.ready) begin
          out_valid_next = 1'b1;
          out_max_next   = front_new ? smp : rd_val;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      occ       <= '0;
      pos       <= '0;
      filled    <= '0;
      out_valid <= 1'b0;
      win       <= WIN_W'(1);
      front_new <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      occ       <= occ_next;
      pos       <= pos_next;
      filled    <= filled_next;
      out_valid <= out_valid_next;
      win       <= win_next;
      front_new <= front_new_next;
    end
    smp     <= smp_next;
    out_max <= out_max_next;
  end

`ifndef SYNTHESIS
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(WINDOW_MAX))
    else $error("deque occupancy beyond capacity");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    32'(head) < 32'(WINDOW_MAX))
    else $error("deque head outside memory");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH |=> occ != '0)
    else $error("deque empty after append");

  a_front_read: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !front_new |-> occ > OW'(1))
    else $error("front read from memory with a single candidate");
`endif

endmodule
